// File: rtl/ocbs_pkg.sv
// shared types, constants and register codes for the outline bounds and corner screen
package ocbs_pkg;

    localparam int COORD_BITS     = 12;
    localparam int MAX_POINTS_DEF = 4096;
    localparam int TOTAL_W        = 13;

    localparam int APB_DW  = 32;
    localparam int PADDR_W = 5;
    localparam int REG_LSB = 2;
    localparam int REG_IDX_W = 3;

    localparam int CFG_DIM_W  = 13;
    localparam int CFG_ASP_W  = 9;
    localparam int CFG_AREA_W = 17;

    localparam int ASPECT_FRAC = 8;
    localparam int AREA_FRAC   = 16;

    localparam logic [CFG_DIM_W-1:0]  IMG_W_RST    = CFG_DIM_W'(640);
    localparam logic [CFG_DIM_W-1:0]  IMG_H_RST    = CFG_DIM_W'(480);
    localparam logic [CFG_ASP_W-1:0]  MIN_ASP_RST  = CFG_ASP_W'(128);
    localparam logic [CFG_AREA_W-1:0] MIN_AREA_RST = CFG_AREA_W'(1966);
    localparam logic [CFG_AREA_W-1:0] MAX_AREA_RST = CFG_AREA_W'(65536);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMG_W    = 3'd0,
        REG_IMG_H    = 3'd1,
        REG_MIN_ASP  = 3'd2,
        REG_MIN_AREA = 3'd3,
        REG_MAX_AREA = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        STAT_PASS   = 3'd0,
        STAT_DEGEN  = 3'd1,
        STAT_ASPECT = 3'd2,
        STAT_SMALL  = 3'd3,
        STAT_LARGE  = 3'd4
    } t_status;

    typedef struct packed {
        logic [CFG_DIM_W-1:0]  img_w;
        logic [CFG_DIM_W-1:0]  img_h;
        logic [CFG_ASP_W-1:0]  min_aspect;
        logic [CFG_AREA_W-1:0] min_area;
        logic [CFG_AREA_W-1:0] max_area;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0] min_x;
        logic [COORD_BITS-1:0] min_y;
        logic [COORD_BITS-1:0] max_x;
        logic [COORD_BITS-1:0] max_y;
    } t_box;

endpackage

// File: rtl/outline_bounds_and_corner_screen.sv
// top level: point store, running box and sums, corner sweep, screening and apb registers
//
// Outline points enter one per cycle and are written into a point memory while the count,
// coordinate sums and bounding box are kept in registers. Once the flagged last point is in,
// input ready drops and the block sweeps the N stored points out of the memory's single read
// port, one per cycle, through a five-stage pipeline (read, scale by N, absolute difference,
// square, sum and compare) that keeps the first point of largest distance from the centroid.
// The box tests run alongside in three register stages. The sweep waits for a previous result
// still held in the output register to be taken. Points arriving when MAX_POINTS are stored
// are dropped and reported through o_overflowed. Register writes over the apb port are meant
// for idle periods.
module outline_bounds_and_corner_screen #(
    parameter int MAX_POINTS = ocbs_pkg::MAX_POINTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ocbs_pkg::COORD_BITS-1:0]   i_point_x,
    input  logic [ocbs_pkg::COORD_BITS-1:0]   i_point_y,
    input  logic                              i_last_point,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_status,
    output logic [ocbs_pkg::COORD_BITS-1:0]   o_box_min_x,
    output logic [ocbs_pkg::COORD_BITS-1:0]   o_box_min_y,
    output logic [ocbs_pkg::COORD_BITS-1:0]   o_box_max_x,
    output logic [ocbs_pkg::COORD_BITS-1:0]   o_box_max_y,
    output logic [ocbs_pkg::COORD_BITS-1:0]   o_corner_x,
    output logic [ocbs_pkg::COORD_BITS-1:0]   o_corner_y,
    output logic [ocbs_pkg::TOTAL_W-1:0]      o_point_total,
    output logic                              o_overflowed,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ocbs_pkg::PADDR_W-1:0]      paddr,
    input  logic [ocbs_pkg::APB_DW-1:0]       pwdata,
    output logic [ocbs_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import ocbs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int DW     = CNT_W + COORD_BITS;
    localparam int SQ_W   = 2 * DW;
    localparam int DIST_W = SQ_W + 1;
    localparam int PT_W   = 2 * COORD_BITS;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_WAIT  = 3'b010,
        ST_SWEEP = 3'b100
    } t_state;

    // configuration
    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     apb_wr;

    // outline accumulators
    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [DW-1:0]         r_sum_x;
    logic [DW-1:0]         n_sum_x;
    logic [DW-1:0]         r_sum_y;
    logic [DW-1:0]         n_sum_y;
    t_box                  r_box;
    t_box                  n_box;
    logic                  r_drop;
    logic                  n_drop;

    // sweep pipeline
    logic [CNT_W-1:0]      r_rd_idx;
    logic [CNT_W-1:0]      n_rd_idx;
    logic                  r_v1, r_v2, r_v3, r_v4;
    logic                  r_f1, r_f2, r_f3, r_f4;
    logic                  r_l1, r_l2, r_l3, r_l4;
    logic [COORD_BITS-1:0] r_px2, r_py2, r_px3, r_py3, r_px4, r_py4;
    logic [DW-1:0]         r_nx, r_ny;
    logic [DW-1:0]         r_dx, r_dy;
    logic [SQ_W-1:0]       r_sq_x, r_sq_y;
    logic [DIST_W-1:0]     r_best;
    logic [COORD_BITS-1:0] r_best_x, r_best_y;

    // result register
    logic                  r_out_valid;
    t_status               r_out_status;
    t_box                  r_out_box;
    logic [COORD_BITS-1:0] r_out_cx, r_out_cy;
    logic [CNT_W-1:0]      r_out_total;
    logic                  r_out_drop;

    logic                  in_xfer;
    logic                  full;
    logic                  issue;
    logic                  finish;
    logic                  take;
    logic [DIST_W-1:0]     cand_dist;
    logic [COORD_BITS-1:0] cand_x, cand_y;
    logic [PT_W-1:0]       rd_data;
    logic [COORD_BITS-1:0] rd_x, rd_y;
    t_status               screen_status;

    // apb registers
    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[REG_LSB +: REG_IDX_W]);

    always_comb begin
        n_cfg = r_cfg;
        if (apb_wr) begin
            case (reg_idx)
                REG_IMG_W:    n_cfg.img_w      = pwdata[CFG_DIM_W-1:0];
                REG_IMG_H:    n_cfg.img_h      = pwdata[CFG_DIM_W-1:0];
                REG_MIN_ASP:  n_cfg.min_aspect = pwdata[CFG_ASP_W-1:0];
                REG_MIN_AREA: n_cfg.min_area   = pwdata[CFG_AREA_W-1:0];
                REG_MAX_AREA: n_cfg.max_area   = pwdata[CFG_AREA_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IMG_W:    prdata = APB_DW'(r_cfg.img_w);
            REG_IMG_H:    prdata = APB_DW'(r_cfg.img_h);
            REG_MIN_ASP:  prdata = APB_DW'(r_cfg.min_aspect);
            REG_MIN_AREA: prdata = APB_DW'(r_cfg.min_area);
            REG_MAX_AREA: prdata = APB_DW'(r_cfg.max_area);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.img_w      <= IMG_W_RST;
            r_cfg.img_h      <= IMG_H_RST;
            r_cfg.min_aspect <= MIN_ASP_RST;
            r_cfg.min_area   <= MIN_AREA_RST;
            r_cfg.max_area   <= MAX_AREA_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // point loading
    assign o_in_ready = (r_state == ST_LOAD);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(MAX_POINTS));

    ocbs_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && !full),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data ({i_point_y, i_point_x}),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_x = rd_data[COORD_BITS-1:0];
    assign rd_y = rd_data[PT_W-1:COORD_BITS];

    // sweep control
    assign issue     = (r_state == ST_SWEEP) && (r_rd_idx < r_count);
    assign cand_dist = DIST_W'(r_sq_x) + DIST_W'(r_sq_y);
    assign take      = r_v4 && (r_f4 || (cand_dist > r_best));
    assign finish    = r_v4 && r_l4;
    assign cand_x    = take ? r_px4 : r_best_x;
    assign cand_y    = take ? r_py4 : r_best_y;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_sum_x  = r_sum_x;
        n_sum_y  = r_sum_y;
        n_box    = r_box;
        n_drop   = r_drop;
        n_rd_idx = r_rd_idx;
        case (r_state)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (full) begin
                        n_drop = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_sum_x = r_sum_x + DW'(i_point_x);
                        n_sum_y = r_sum_y + DW'(i_point_y);
                        if (i_point_x < r_box.min_x) n_box.min_x = i_point_x;
                        if (i_point_y < r_box.min_y) n_box.min_y = i_point_y;
                        if (i_point_x > r_box.max_x) n_box.max_x = i_point_x;
                        if (i_point_y > r_box.max_y) n_box.max_y = i_point_y;
                    end
                    if (i_last_point) begin
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (!r_out_valid) begin
                    n_state  = ST_SWEEP;
                    n_rd_idx = '0;
                end
            end
            ST_SWEEP: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (finish) begin
                    n_state     = ST_LOAD;
                    n_count     = '0;
                    n_sum_x     = '0;
                    n_sum_y     = '0;
                    n_box.min_x = '1;
                    n_box.min_y = '1;
                    n_box.max_x = '0;
                    n_box.max_y = '0;
                    n_drop      = 1'b0;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_box.min_x <= '1;
            r_box.min_y <= '1;
            r_box.max_x <= '0;
            r_box.max_y <= '0;
            r_drop      <= 1'b0;
            r_rd_idx    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sum_x  <= n_sum_x;
            r_sum_y  <= n_sum_y;
            r_box    <= n_box;
            r_drop   <= n_drop;
            r_rd_idx <= n_rd_idx;
            r_v1     <= issue;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
        end
    end

    // sweep datapath
    always_ff @(posedge i_clk) begin
        r_f1  <= (r_rd_idx == '0);
        r_l1  <= (r_rd_idx == r_count - 1'b1);

        r_f2  <= r_f1;
        r_l2  <= r_l1;
        r_px2 <= rd_x;
        r_py2 <= rd_y;
        r_nx  <= DW'(r_count) * DW'(rd_x);
        r_ny  <= DW'(r_count) * DW'(rd_y);

        r_f3  <= r_f2;
        r_l3  <= r_l2;
        r_px3 <= r_px2;
        r_py3 <= r_py2;
        r_dx  <= (r_nx >= r_sum_x) ? (r_nx - r_sum_x) : (r_sum_x - r_nx);
        r_dy  <= (r_ny >= r_sum_y) ? (r_ny - r_sum_y) : (r_sum_y - r_ny);

        r_f4   <= r_f3;
        r_l4   <= r_l3;
        r_px4  <= r_px3;
        r_py4  <= r_py3;
        r_sq_x <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sq_y <= SQ_W'(r_dy) * SQ_W'(r_dy);

        if (take) begin
            r_best   <= cand_dist;
            r_best_x <= r_px4;
            r_best_y <= r_py4;
        end
    end

    ocbs_screen u_screen (
        .i_clk    (i_clk),
        .i_box    (r_box),
        .i_cfg    (r_cfg),
        .o_status (screen_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_status <= screen_status;
            r_out_box    <= r_box;
            r_out_cx     <= cand_x;
            r_out_cy     <= cand_y;
            r_out_total  <= r_count;
            r_out_drop   <= r_drop;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_box_min_x   = r_out_box.min_x;
    assign o_box_min_y   = r_out_box.min_y;
    assign o_box_max_x   = r_out_box.max_x;
    assign o_box_max_y   = r_out_box.max_y;
    assign o_corner_x    = r_out_cx;
    assign o_corner_y    = r_out_cy;
    assign o_point_total = TOTAL_W'(r_out_total);
    assign o_overflowed  = r_out_drop;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_sweep_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SWEEP |-> r_count != '0)
        else $error("sweep started on an empty outline");

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> !r_out_valid)
        else $error("result overwrites an untaken transaction");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_count == '0 && r_state == ST_LOAD && !r_v1))
        else $error("outline not cleared after result");

    a_pipe_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_state == ST_SWEEP)
        else $error("sweep pipeline active outside sweep");
`endif

endmodule

// File: rtl/ocbs_ram.sv
// generic simple dual-port ram with registered read
module ocbs_ram #(
    parameter int WIDTH = 2 * ocbs_pkg::COORD_BITS,
    parameter int DEPTH = ocbs_pkg::MAX_POINTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/ocbs_screen.sv
// box screening: degenerate, aspect and area tests over three register stages
module ocbs_screen (
    input  logic             i_clk,
    input  ocbs_pkg::t_box   i_box,
    input  ocbs_pkg::t_cfg   i_cfg,
    output ocbs_pkg::t_status o_status
);
    import ocbs_pkg::*;

    localparam int IMG_AREA_W = 2 * CFG_DIM_W;
    localparam int ASP_W      = COORD_BITS + CFG_ASP_W;
    localparam int WH_W       = 2 * COORD_BITS;
    localparam int AREA_W     = CFG_AREA_W + IMG_AREA_W;

    logic [COORD_BITS-1:0] r_w;
    logic [COORD_BITS-1:0] r_h;
    logic [IMG_AREA_W-1:0] r_img;

    logic                  r_degen;
    logic                  r_asp_fail;
    logic [WH_W-1:0]       r_wh;
    logic [AREA_W-1:0]     r_lo;
    logic [AREA_W-1:0]     r_hi;

    t_status               r_status;

    logic [COORD_BITS-1:0] short_side;
    logic [COORD_BITS-1:0] long_side;
    logic [AREA_W-1:0]     feat;

    assign short_side = (r_w < r_h) ? r_w : r_h;
    assign long_side  = (r_w < r_h) ? r_h : r_w;
    assign feat       = AREA_W'(r_wh) << AREA_FRAC;

    // stage 1: sides and image area
    always_ff @(posedge i_clk) begin
        r_w   <= i_box.max_x - i_box.min_x;
        r_h   <= i_box.max_y - i_box.min_y;
        r_img <= IMG_AREA_W'(i_cfg.img_w) * IMG_AREA_W'(i_cfg.img_h);
    end

    // stage 2: degenerate and aspect tests and area products
    always_ff @(posedge i_clk) begin
        r_degen    <= (r_w == '0) || (r_h == '0);
        r_asp_fail <= (r_w != r_h) &&
                      ((ASP_W'(short_side) << ASPECT_FRAC) <
                       (ASP_W'(i_cfg.min_aspect) * ASP_W'(long_side)));
        r_wh       <= WH_W'(r_w) * WH_W'(r_h);
        r_lo       <= AREA_W'(i_cfg.min_area) * AREA_W'(r_img);
        r_hi       <= AREA_W'(i_cfg.max_area) * AREA_W'(r_img);
    end

    // stage 3: verdict in priority order
    always_ff @(posedge i_clk) begin
        if (r_degen) begin
            r_status <= STAT_DEGEN;
        end else if (r_asp_fail) begin
            r_status <= STAT_ASPECT;
        end else if (feat < r_lo) begin
            r_status <= STAT_SMALL;
        end else if (feat > r_hi) begin
            r_status <= STAT_LARGE;
        end else begin
            r_status <= STAT_PASS;
        end
    end

    assign o_status = r_status;

endmodule
